@@ src/lcd4_pkg.sv @@
// shared types, codes and control program for the 4-bit character lcd sequencer
package lcd4_pkg;

   // input commands
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_INSTR = 2'd1;
   localparam logic [1:0] CMD_POS   = 2'd2;
   localparam logic [1:0] CMD_INIT  = 2'd3;

   localparam int PC_W = 6;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type BYTE_ENTRY = 6'd0;
   localparam pc_type INIT_ENTRY = 6'd5;

   // rs source
   localparam logic [1:0] RS_ZERO = 2'd0;
   localparam logic [1:0] RS_ONE  = 2'd1;
   localparam logic [1:0] RS_ITEM = 2'd2;

   // nibble source
   localparam logic [1:0] D_CONST = 2'd0;
   localparam logic [1:0] D_HI    = 2'd1;
   localparam logic [1:0] D_LO    = 2'd2;

   // backlight source
   localparam logic [1:0] BL_KEEP = 2'd0;
   localparam logic [1:0] BL_ZERO = 2'd1;
   localparam logic [1:0] BL_ONE  = 2'd2;

   // wait base
   localparam logic [1:0] W_NONE    = 2'd0;
   localparam logic [1:0] W_STROBE  = 2'd1;
   localparam logic [1:0] W_STROBE2 = 2'd2;
   localparam logic [1:0] W_TAIL    = 2'd3;

   // wait addend
   localparam logic [2:0] K_NONE  = 3'd0;
   localparam logic [2:0] K_1MS   = 3'd1;
   localparam logic [2:0] K_5MS   = 3'd2;
   localparam logic [2:0] K_10MS  = 3'd3;
   localparam logic [2:0] K_50MS  = 3'd4;
   localparam logic [2:0] K_120MS = 3'd5;

   localparam logic [9:0] STROBE_RESET = 10'd100;

   typedef struct packed {
      logic       hold;
      logic [1:0] rs_sel;
      logic       e;
      logic [1:0] d_sel;
      logic [3:0] d_const;
      logic [1:0] bl_sel;
      logic [1:0] w_sel;
      logic [2:0] k_sel;
      logic       last;
   } lcd4_ctrl_type;

   typedef struct packed {
      logic        reg_select;
      logic        enable;
      logic [3:0]  data_nibble;
      logic        backlight;
      logic [18:0] wait_us;
      logic        last;
   } lcd4_snap_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] byte_value;
      logic [5:0] column;
      logic       row;
      logic [7:0] extra_wait_ms;
   } lcd4_item_type;

   function automatic logic [18:0] lcd4_wait_const(input logic [2:0] k);
      logic [18:0] v;
      unique case (k)
         K_NONE:  v = 19'd0;
         K_1MS:   v = 19'd1000;
         K_5MS:   v = 19'd5000;
         K_10MS:  v = 19'd10000;
         K_50MS:  v = 19'd50000;
         K_120MS: v = 19'd120000;
         default: v = 19'd0;
      endcase
      return v;
   endfunction

   function automatic lcd4_ctrl_type cw(input logic hold, input logic [1:0] rs,
                                        input logic e, input logic [1:0] ds,
                                        input logic [3:0] dc, input logic [1:0] bl,
                                        input logic [1:0] ws, input logic [2:0] ks,
                                        input logic last);
      lcd4_ctrl_type w;
      w.hold    = hold;
      w.rs_sel  = rs;
      w.e       = e;
      w.d_sel   = ds;
      w.d_const = dc;
      w.bl_sel  = bl;
      w.w_sel   = ws;
      w.k_sel   = ks;
      w.last    = last;
      return w;
   endfunction

   // control program: byte write at 0, init sequence at 5
   function automatic lcd4_ctrl_type lcd4_rom(input pc_type pc);
      lcd4_ctrl_type w;
      unique case (pc)
         // byte write
         6'd0:  w = cw(1'b0, RS_ITEM, 1'b1, D_HI, 4'h0, BL_KEEP, W_STROBE, K_NONE, 1'b0);
         6'd1:  w = cw(1'b0, RS_ITEM, 1'b0, D_HI, 4'h0, BL_KEEP, W_STROBE, K_NONE, 1'b0);
         6'd2:  w = cw(1'b0, RS_ITEM, 1'b1, D_LO, 4'h0, BL_KEEP, W_STROBE, K_NONE, 1'b0);
         6'd3:  w = cw(1'b0, RS_ITEM, 1'b0, D_LO, 4'h0, BL_KEEP, W_STROBE2, K_NONE, 1'b0);
         6'd4:  w = cw(1'b0, RS_ONE, 1'b0, D_LO, 4'h0, BL_KEEP, W_TAIL, K_NONE, 1'b1);
         // init: hold pins, all low, wake-up nibbles
         6'd5:  w = cw(1'b1, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_KEEP, W_NONE, K_120MS, 1'b0);
         6'd6:  w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_ZERO, W_NONE, K_50MS, 1'b0);
         6'd7:  w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd8:  w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_10MS, 1'b0);
         6'd9:  w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd10: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_10MS, 1'b0);
         6'd11: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd12: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h3, BL_ZERO, W_STROBE, K_10MS, 1'b0);
         6'd13: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h2, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd14: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h2, BL_ZERO, W_STROBE, K_5MS, 1'b0);
         // function set 0x28
         6'd15: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h2, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd16: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h2, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd17: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h8, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd18: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h8, BL_ZERO, W_STROBE2, K_NONE, 1'b0);
         6'd19: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'h8, BL_ZERO, W_NONE, K_1MS, 1'b0);
         // display off 0x08
         6'd20: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd21: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd22: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h8, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd23: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h8, BL_ZERO, W_STROBE2, K_NONE, 1'b0);
         6'd24: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'h8, BL_ZERO, W_NONE, K_1MS, 1'b0);
         // clear 0x01
         6'd25: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd26: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd27: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h1, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd28: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h1, BL_ZERO, W_STROBE2, K_NONE, 1'b0);
         6'd29: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'h1, BL_ZERO, W_NONE, K_10MS, 1'b0);
         // entry mode 0x06
         6'd30: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd31: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd32: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h6, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd33: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h6, BL_ZERO, W_STROBE2, K_NONE, 1'b0);
         6'd34: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'h6, BL_ZERO, W_NONE, K_5MS, 1'b0);
         // display on 0x0c
         6'd35: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd36: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd37: w = cw(1'b0, RS_ZERO, 1'b1, D_CONST, 4'hC, BL_ZERO, W_STROBE, K_NONE, 1'b0);
         6'd38: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'hC, BL_ZERO, W_STROBE2, K_NONE, 1'b0);
         6'd39: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'hC, BL_ZERO, W_NONE, K_10MS, 1'b0);
         // backlight on
         6'd40: w = cw(1'b0, RS_ONE, 1'b0, D_CONST, 4'hC, BL_ONE, W_TAIL, K_NONE, 1'b1);
         default: w = cw(1'b0, RS_ZERO, 1'b0, D_CONST, 4'h0, BL_KEEP, W_NONE, K_NONE, 1'b1);
      endcase
      return w;
   endfunction

endpackage

@@ src/lcd4_if.sv @@
// handshake channel interfaces for the lcd sequencer
interface lcd4_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] byte_value;
   logic [5:0] column;
   logic       row;
   logic [7:0] extra_wait_ms;
   modport source (output valid, command, byte_value, column, row, extra_wait_ms,
                   input ready);
   modport sink (input valid, command, byte_value, column, row, extra_wait_ms,
                 output ready);
endinterface

interface lcd4_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic        enable;
   logic [3:0]  data_nibble;
   logic        backlight;
   logic [18:0] wait_us;
   logic        last;
   modport source (output valid, reg_select, enable, data_nibble, backlight, wait_us,
                   last, input ready);
   modport sink (input valid, reg_select, enable, data_nibble, backlight, wait_us,
                 last, output ready);
endinterface

interface lcd4_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] strobe_wait_us;
   modport source (output valid, strobe_wait_us, input ready);
   modport sink (input valid, strobe_wait_us, output ready);
endinterface

@@ src/char_lcd_4bit_sequencer_unit.sv @@
// top level of the 4-bit character lcd sequencer
//
// req_chan takes one operation per transfer: data write, instruction write,
// set position or the power-on init sequence. rsp_chan returns a run of pin
// snapshots (rs, e, d4..d7, backlight) each with the time in microseconds to
// hold it; last marks the final snapshot of a run. csr_chan writes the strobe
// wait and is always ready; write it only while the block is idle.
// a write run is 5 snapshots, an init run 36. after the request transfer the
// step counter is set, then the first snapshot is loaded into the output
// register; then one snapshot per cycle while the receiver takes them. the
// rate is set by the control program stepping one word per snapshot.
// req_chan is ready again the cycle after the last snapshot is loaded, even if
// that snapshot still waits in the output register.
// a stall on rsp_chan freezes the step counter and holds the snapshot.
// reset empties the output register, clears all pins to low (backlight off)
// and sets the strobe wait to 100 us.
module char_lcd_4bit_sequencer_unit
   import lcd4_pkg::*;
(
   input logic        clock,
   input logic        reset,
   lcd4_req_if.sink   req_chan,
   lcd4_rsp_if.source rsp_chan,
   lcd4_csr_if.sink   csr_chan
);

   logic [9:0]    strobe_ff, strobe_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          start;
   logic          advance;
   logic          busy;
   lcd4_ctrl_type ctrl;
   lcd4_snap_type snap;
   lcd4_item_type item;

   // strobe wait register
   assign csr_chan.ready = 1'b1;
   assign strobe_in = (csr_chan.valid) ? csr_chan.strobe_wait_us : strobe_ff;

   // one operation at a time
   assign req_chan.ready = !busy;
   assign start          = req_chan.valid && !busy;

   // load a new snapshot whenever the output register is free or being drained
   assign advance = busy && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      item.command       = req_chan.command;
      item.byte_value    = req_chan.byte_value;
      item.column        = req_chan.column;
      item.row           = req_chan.row;
      item.extra_wait_ms = req_chan.extra_wait_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff    <= STROBE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         strobe_ff    <= strobe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   lcd4_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_chan.command),
      .advance (advance),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   lcd4_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .item           (item),
      .strobe_wait_us (strobe_ff),
      .advance        (advance),
      .ctrl           (ctrl),
      .snap           (snap)
   );

   // result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reg_select  = snap.reg_select;
   assign rsp_chan.enable      = snap.enable;
   assign rsp_chan.data_nibble = snap.data_nibble;
   assign rsp_chan.backlight   = snap.backlight;
   assign rsp_chan.wait_us     = snap.wait_us;
   assign rsp_chan.last        = snap.last;

   // the last program word ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      advance && ctrl.last |=> !busy)
      else $error("sequencer still busy after last snapshot");

   // a stalled receiver freezes the program
   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      busy && rsp_valid_ff && !rsp_chan.ready |=> $stable(ctrl))
      else $error("control word moved during output stall");

   // every loaded snapshot is offered
   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("snapshot loaded but not offered");

endmodule

@@ src/lcd4_sequencer.sv @@
// step counter and control store of the lcd sequencer
module lcd4_sequencer
   import lcd4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    command,
   input  logic          advance,
   output lcd4_ctrl_type ctrl,
   output logic          busy
);

   pc_type pc_ff, pc_in;
   logic   busy_ff, busy_in;

   assign ctrl = lcd4_rom(pc_ff);
   assign busy = busy_ff;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         // dispatch jump
         pc_in   = (command == CMD_INIT) ? INIT_ENTRY : BYTE_ENTRY;
         busy_in = 1'b1;
      end else if (advance) begin
         if (ctrl.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= BYTE_ENTRY;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ src/lcd4_datapath.sv @@
// item registers, pin image and snapshot output register
module lcd4_datapath
   import lcd4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  lcd4_item_type item,
   input  logic [9:0]    strobe_wait_us,
   input  logic          advance,
   input  lcd4_ctrl_type ctrl,
   output lcd4_snap_type snap
);

   logic [7:0]    byte_ff, byte_in;
   logic          rs_item_ff, rs_item_in;
   logic [17:0]   tail_ff, tail_in;
   lcd4_snap_type snap_ff, snap_in;
   logic [6:0]    pos_sum;
   logic [18:0]   wait_base;

   assign snap = snap_ff;

   // item capture
   always_comb begin
      pos_sum    = (item.row ? 7'h40 : 7'h00) + {1'b0, item.column};
      byte_in    = (item.command == CMD_POS) ? {1'b1, pos_sum} : item.byte_value;
      rs_item_in = (item.command == CMD_DATA);
      tail_in    = 18'(item.extra_wait_ms) * 18'd1000;
   end

   // snapshot formation
   always_comb begin
      snap_in = snap_ff;
      unique case (ctrl.w_sel)
         W_NONE:    wait_base = 19'd0;
         W_STROBE:  wait_base = {9'd0, strobe_wait_us};
         W_STROBE2: wait_base = {8'd0, strobe_wait_us, 1'b0};
         W_TAIL:    wait_base = {1'b0, tail_ff};
         default:   wait_base = 19'd0;
      endcase
      snap_in.wait_us = wait_base + lcd4_wait_const(ctrl.k_sel);
      snap_in.last    = ctrl.last;
      if (!ctrl.hold) begin
         unique case (ctrl.rs_sel)
            RS_ZERO: snap_in.reg_select = 1'b0;
            RS_ONE:  snap_in.reg_select = 1'b1;
            RS_ITEM: snap_in.reg_select = rs_item_ff;
            default: snap_in.reg_select = 1'b0;
         endcase
         snap_in.enable = ctrl.e;
         unique case (ctrl.d_sel)
            D_CONST: snap_in.data_nibble = ctrl.d_const;
            D_HI:    snap_in.data_nibble = byte_ff[7:4];
            D_LO:    snap_in.data_nibble = byte_ff[3:0];
            default: snap_in.data_nibble = ctrl.d_const;
         endcase
         unique case (ctrl.bl_sel)
            BL_KEEP: snap_in.backlight = snap_ff.backlight;
            BL_ZERO: snap_in.backlight = 1'b0;
            BL_ONE:  snap_in.backlight = 1'b1;
            default: snap_in.backlight = snap_ff.backlight;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         byte_ff    <= byte_in;
         rs_item_ff <= rs_item_in;
         tail_ff    <= tail_in;
      end
   end

   // the pin fields double as the pin image, so they are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= '0;
      end else if (advance) begin
         snap_ff <= snap_in;
      end
   end

endmodule

@@ sim/tb_char_lcd_4bit_sequencer_unit.sv @@
// self-checking testbench for the 4-bit character lcd sequencer, against its own pin-run predictor
`timescale 1ns / 100ps

module tb_char_lcd_4bit_sequencer_unit
   import lcd4_pkg::*;
();

   // power-on waits of the init run, in microseconds
   localparam logic [18:0] WAIT_PWRON_US  = 19'd120000;
   localparam logic [18:0] WAIT_SETTLE_US = 19'd50000;
   localparam logic [18:0] WAIT_1MS       = 19'd1000;
   localparam logic [18:0] WAIT_5MS       = 19'd5000;
   localparam logic [18:0] WAIT_10MS      = 19'd10000;

   // wake-up nibbles and instruction bytes of the init run
   localparam logic [3:0] NIB_WAKE   = 4'h3;
   localparam logic [3:0] NIB_4BIT   = 4'h2;
   localparam logic [3:0] NIB_DISPON = 4'hC;
   localparam logic [7:0] INS_FN_SET   = 8'h28;
   localparam logic [7:0] INS_DISP_OFF = 8'h08;
   localparam logic [7:0] INS_CLEAR    = 8'h01;
   localparam logic [7:0] INS_ENTRY    = 8'h06;
   localparam logic [7:0] INS_DISP_ON  = 8'h0C;
   localparam logic [6:0] ROW1_BASE    = 7'h40;
   localparam logic [7:0] INS_SET_DDRAM = 8'h80;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 500;     // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 40;     // look for stray snapshots once all are in
   localparam int PHASE_ITEMS = 27;
   localparam int N_PHASES = 6;
   localparam int MAX_PRINTED = 40;

   // one line of the directed stimulus table: a strobe write or an operation
   typedef struct {
      bit            is_cfg;
      logic [9:0]    strobe;
      lcd4_item_type op;
      bit            typed;   // fin holds the hand-written last snapshot
      lcd4_snap_type fin;
   } dir_row_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   err_count = 0;
   bit   in_reset = 1'b1;
   bit   req_offered = 1'b0;
   bit   rsp_hold_req = 1'b0;

   // predictor state: strobe wait register and the pin image
   logic [9:0] strobe_us = STROBE_RESET;
   logic       pin_rs = 1'b0;
   logic       pin_e = 1'b0;
   logic [3:0] pin_d = 4'h0;
   logic       pin_bl = 1'b0;

   // snapshots still owed by the block, oldest first
   lcd4_snap_type snap_expect_q[$];

   lcd4_req_if req_bus ();
   lcd4_rsp_if rsp_bus ();
   lcd4_csr_if csr_bus ();

   char_lcd_4bit_sequencer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d snapshots outstanding",
                  cycle_count, snap_expect_q.size());
         $display("tb_char_lcd_4bit_sequencer_unit: done, errors");
         $finish;
      end
   end

   task automatic report(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------
   // pin-run predictor
   // ---------------------------------------------------------------------------

   // each snapshot is the whole pin state, so it also becomes the new pin image
   task automatic push_pins(input logic rs, input logic e, input logic [3:0] d,
                            input logic bl, input logic [18:0] w, input logic lst);
      lcd4_snap_type s;
      s.reg_select  = rs;
      s.enable      = e;
      s.data_nibble = d;
      s.backlight   = bl;
      s.wait_us     = w;
      s.last        = lst;
      pin_rs = rs;
      pin_e  = e;
      pin_d  = d;
      pin_bl = bl;
      snap_expect_q.push_back(s);
   endtask

   // one e pulse: high for the strobe wait, then low for low_wait
   task automatic strobe_pins(input logic rs, input logic [3:0] d, input logic [18:0] low_wait);
      push_pins(rs, 1'b1, d, pin_bl, 19'(strobe_us), 1'b0);
      push_pins(rs, 1'b0, d, pin_bl, low_wait, 1'b0);
   endtask

   // high nibble, low nibble (double wait after its falling edge), then rs raised
   task automatic send_byte_pins(input logic rs, input logic [7:0] b,
                                 input logic [18:0] fin_wait, input logic lst);
      strobe_pins(rs, b[7:4], 19'(strobe_us));
      strobe_pins(rs, b[3:0], 19'(strobe_us) << 1);
      push_pins(1'b1, 1'b0, b[3:0], pin_bl, fin_wait, lst);
   endtask

   task automatic predict_pin_run(input lcd4_item_type it);
      logic [18:0] tail;
      logic [6:0]  pos;
      tail = 19'(it.extra_wait_ms) * 19'd1000;
      // columns past the display width are added as they are, no wrap in 7 bits
      pos = (it.row ? ROW1_BASE : 7'h00) + 7'(it.column);
      case (it.command)
         CMD_DATA:  send_byte_pins(1'b1, it.byte_value, tail, 1'b1);
         CMD_INSTR: send_byte_pins(1'b0, it.byte_value, tail, 1'b1);
         CMD_POS:   send_byte_pins(1'b0, INS_SET_DDRAM | {1'b0, pos}, tail, 1'b1);
         default: begin
            // hold whatever is on the pins, then drop everything incl. backlight
            push_pins(pin_rs, pin_e, pin_d, pin_bl, WAIT_PWRON_US, 1'b0);
            push_pins(1'b0, 1'b0, 4'h0, 1'b0, WAIT_SETTLE_US, 1'b0);
            repeat (3) strobe_pins(1'b0, NIB_WAKE, 19'(strobe_us) + WAIT_10MS);
            strobe_pins(1'b0, NIB_4BIT, 19'(strobe_us) + WAIT_5MS);
            send_byte_pins(1'b0, INS_FN_SET, WAIT_1MS, 1'b0);
            send_byte_pins(1'b0, INS_DISP_OFF, WAIT_1MS, 1'b0);
            send_byte_pins(1'b0, INS_CLEAR, WAIT_10MS, 1'b0);
            send_byte_pins(1'b0, INS_ENTRY, WAIT_5MS, 1'b0);
            send_byte_pins(1'b0, INS_DISP_ON, WAIT_10MS, 1'b0);
            // backlight comes on with the closing snapshot
            push_pins(1'b1, 1'b0, NIB_DISPON, 1'b1, tail, 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offer one operation after a gap; the predictor runs at the transfer edge.
   // valid stays high afterwards so a following item with no gap goes back to back
   task automatic offer_item(input lcd4_item_type it, input int gap);
      // valid was dropped in this very step: never raise it again in the same step
      if (!req_offered && gap == 0)
         gap = 1;
      if (gap > 0) begin
         if (req_offered) begin
            req_bus.valid <= 1'b0;
            req_offered = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= it.command;
      req_bus.byte_value    <= it.byte_value;
      req_bus.column        <= it.column;
      req_bus.row           <= it.row;
      req_bus.extra_wait_ms <= it.extra_wait_ms;
      req_offered = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_pin_run(it);
   endtask

   // stop offering and wait until every owed snapshot has been taken
   task automatic settle_idle();
      if (req_offered) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (snap_expect_q.size() != 0) @(posedge clock);
   endtask

   // strobe wait is only written with the block idle
   task automatic write_strobe(input logic [9:0] v);
      settle_idle();
      csr_bus.valid          <= 1'b1;
      csr_bus.strobe_wait_us <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      strobe_us = v;
   endtask

   function automatic dir_row_type op_row(input logic [1:0] cmd, input logic [7:0] b,
                                          input logic [5:0] col, input logic r,
                                          input logic [7:0] ex, input bit typed = 1'b0,
                                          input lcd4_snap_type fin = '0);
      dir_row_type row_v;
      row_v.is_cfg           = 1'b0;
      row_v.strobe           = '0;
      row_v.op.command       = cmd;
      row_v.op.byte_value    = b;
      row_v.op.column        = col;
      row_v.op.row           = r;
      row_v.op.extra_wait_ms = ex;
      row_v.typed            = typed;
      row_v.fin              = fin;
      return row_v;
   endfunction

   function automatic dir_row_type cfg_row(input logic [9:0] v);
      dir_row_type row_v;
      row_v = op_row(CMD_DATA, 8'h00, 6'd0, 1'b0, 8'd0);
      row_v.is_cfg = 1'b1;
      row_v.strobe = v;
      return row_v;
   endfunction

   // closing snapshot of any run: rs high, e low, last set
   function automatic lcd4_snap_type end_snap(input logic [3:0] d, input logic bl,
                                              input logic [18:0] w);
      return {1'b1, 1'b0, d, bl, w, 1'b1};
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin
      dir_row_type   dir_rows[$];
      lcd4_item_type it;
      logic [9:0]    phase_strobe [N_PHASES];
      int            sel;
      int            gap;

      // every input known from time zero
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.command        <= CMD_DATA;
      req_bus.byte_value     <= '0;
      req_bus.column         <= '0;
      req_bus.row            <= 1'b0;
      req_bus.extra_wait_ms  <= '0;
      rsp_bus.ready          <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.strobe_wait_us <= '0;

      // directed part: backlight off until an init has run, byte and position
      // extremes, columns past the display width, strobe wait at 0, 1023 and
      // its reset value, init with the backlight both off and on
      dir_rows.push_back(op_row(CMD_DATA, 8'hA5, 6'd0, 1'b0, 8'd0, 1'b1,
                                end_snap(4'h5, 1'b0, 19'd0)));
      dir_rows.push_back(op_row(CMD_INSTR, 8'h00, 6'd0, 1'b0, 8'd0, 1'b1,
                                end_snap(4'h0, 1'b0, 19'd0)));
      dir_rows.push_back(op_row(CMD_POS, 8'h00, 6'd0, 1'b0, 8'd1, 1'b1,
                                end_snap(4'h0, 1'b0, 19'd1000)));
      dir_rows.push_back(op_row(CMD_POS, 8'h00, 6'd39, 1'b1, 8'd2));
      dir_rows.push_back(op_row(CMD_POS, 8'hFF, 6'd63, 1'b1, 8'd3));
      dir_rows.push_back(op_row(CMD_POS, 8'h00, 6'd63, 1'b0, 8'd0));
      dir_rows.push_back(op_row(CMD_DATA, 8'h3C, 6'd21, 1'b1, 8'd4));
      dir_rows.push_back(cfg_row(10'd0));
      dir_rows.push_back(op_row(CMD_DATA, 8'hFF, 6'd0, 1'b0, 8'd255, 1'b1,
                                end_snap(4'hF, 1'b0, 19'd255000)));
      dir_rows.push_back(op_row(CMD_INIT, 8'h00, 6'd0, 1'b0, 8'd0, 1'b1,
                                end_snap(NIB_DISPON, 1'b1, 19'd0)));
      dir_rows.push_back(op_row(CMD_DATA, 8'h00, 6'd0, 1'b0, 8'd0, 1'b1,
                                end_snap(4'h0, 1'b1, 19'd0)));
      dir_rows.push_back(cfg_row(10'd1023));
      dir_rows.push_back(op_row(CMD_INSTR, INS_CLEAR, 6'd0, 1'b0, 8'd5));
      dir_rows.push_back(op_row(CMD_INIT, 8'hFF, 6'd63, 1'b1, 8'd255, 1'b1,
                                end_snap(NIB_DISPON, 1'b1, 19'd255000)));
      dir_rows.push_back(cfg_row(10'd1000));
      dir_rows.push_back(op_row(CMD_DATA, 8'h5A, 6'd0, 1'b0, 8'd10));
      dir_rows.push_back(op_row(CMD_POS, 8'h00, 6'd20, 1'b0, 8'd0));
      dir_rows.push_back(op_row(CMD_INSTR, 8'hFF, 6'd0, 1'b0, 8'd255, 1'b1,
                                end_snap(4'hF, 1'b1, 19'd255000)));
      dir_rows.push_back(cfg_row(STROBE_RESET));
      dir_rows.push_back(op_row(CMD_INIT, 8'h00, 6'd0, 1'b0, 8'd1));

      // synchronous reset, once
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      in_reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            write_strobe(dir_rows[i].strobe);
         end else begin
            offer_item(dir_rows[i].op, $urandom_range(0, 10));
            // hand-written closing snapshot replaces the predicted one
            if (dir_rows[i].typed)
               snap_expect_q[snap_expect_q.size() - 1] = dir_rows[i].fin;
         end
      end

      // random part: one strobe setting per phase, extremes included
      phase_strobe[0] = 10'd1023;
      phase_strobe[1] = 10'd0;
      phase_strobe[2] = 10'd1;
      phase_strobe[3] = 10'd1000;
      phase_strobe[4] = 10'($urandom_range(0, 1023));
      phase_strobe[5] = STROBE_RESET;

      for (int p = 0; p < N_PHASES; p++) begin
         write_strobe(phase_strobe[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // receiver holds off for a long stretch while items keep coming
            if (p == 1 && i == 8)
               rsp_hold_req = 1'b1;
            // sender pauses until the block has handed over everything
            if (p == 3 && i == 12)
               settle_idle();
            sel = $urandom_range(0, 99);
            if (sel < 35)
               it.command = CMD_DATA;
            else if (sel < 60)
               it.command = CMD_INSTR;
            else if (sel < 88)
               it.command = CMD_POS;
            else
               it.command = CMD_INIT;
            it.byte_value    = 8'($urandom_range(0, 255));
            it.column        = 6'($urandom_range(0, 63));
            it.row           = 1'($urandom_range(0, 1));
            it.extra_wait_ms = 8'($urandom_range(0, 255));
            // two phases run the request side flat out
            gap = (p == 2 || p == 4) ? 0 : $urandom_range(0, 10);
            offer_item(it, gap);
         end
      end

      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("tb_char_lcd_4bit_sequencer_unit: done, clean");
      else
         $display("tb_char_lcd_4bit_sequencer_unit: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // result side: random stalls, one long hold-off, field-by-field check
   // ---------------------------------------------------------------------------
   initial begin
      int            stall;
      int            seen;
      bit            rdy;
      lcd4_snap_type got;
      lcd4_snap_type want;

      seen = 0;
      rdy  = 1'b0;
      while (in_reset) @(posedge clock);
      forever begin
         // every third block of 80 snapshots is taken without stalls
         stall = ((seen / 80) % 3 == 1) ? 0 : $urandom_range(0, 10);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            if (rdy) begin
               rsp_bus.ready <= 1'b0;
               rdy = 1'b0;
            end
            repeat (stall) @(posedge clock);
         end
         if (!rdy) begin
            rsp_bus.ready <= 1'b1;
            rdy = 1'b1;
         end
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);

         // transfer at this edge
         got.reg_select  = rsp_bus.reg_select;
         got.enable      = rsp_bus.enable;
         got.data_nibble = rsp_bus.data_nibble;
         got.backlight   = rsp_bus.backlight;
         got.wait_us     = rsp_bus.wait_us;
         got.last        = rsp_bus.last;
         if (snap_expect_q.size() == 0) begin
            report($sformatf("snapshot %0d arrived with none owed", seen));
         end else begin
            want = snap_expect_q.pop_front();
            if (got.reg_select !== want.reg_select)
               report($sformatf("snapshot %0d rs %b, want %b", seen,
                                got.reg_select, want.reg_select));
            if (got.enable !== want.enable)
               report($sformatf("snapshot %0d e %b, want %b", seen,
                                got.enable, want.enable));
            if (got.data_nibble !== want.data_nibble)
               report($sformatf("snapshot %0d d4..d7 %h, want %h", seen,
                                got.data_nibble, want.data_nibble));
            if (got.backlight !== want.backlight)
               report($sformatf("snapshot %0d backlight %b, want %b", seen,
                                got.backlight, want.backlight));
            if (got.wait_us !== want.wait_us)
               report($sformatf("snapshot %0d wait %0d us, want %0d us", seen,
                                got.wait_us, want.wait_us));
            if (got.last !== want.last)
               report($sformatf("snapshot %0d last %b, want %b", seen,
                                got.last, want.last));
         end
         seen++;
      end
   end

endmodule

@@ files.f @@
src/lcd4_pkg.sv
src/lcd4_if.sv
src/lcd4_sequencer.sv
src/lcd4_datapath.sv
src/char_lcd_4bit_sequencer_unit.sv
sim/tb_char_lcd_4bit_sequencer_unit.sv
